[src/piqp_pkg.sv]
// Shared types and constants for the positional-insert queue pair.
package piqp_pkg;

  localparam int DEF_DEPTH      = 16;
  localparam int DEF_NAME_BYTES = 8;

  localparam int CMD_W    = 3;
  localparam int NAME_W   = 64;
  localparam int NUM_W    = 16;
  localparam int SEM_W    = 4;
  localparam int MCNT_W   = 5;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_READ_W = 3'd4,
    CMD_READ_G = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the accepted item
    logic setup;   // evaluate the command, latch status
    logic ld_ins;  // arm insert shift stream
    logic ld_copy; // arm waiting-to-granted copy stream
    logic ld_cmp;  // arm waiting compaction stream
    logic stream;  // stream engine may step
    logic place;   // write new record into its slot
    logic fin;     // load result registers
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_put;
    logic is_rem;
    logic is_move;
    logic full;
    logic empty;
    logic done;
  } sts_t;

endpackage

[src/piqp_ctrl.sv]
// Command sequencer for the positional-insert queue pair.
module piqp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  piqp_pkg::sts_t  sts,
  output piqp_pkg::ctl_t  ctl,
  output logic            busy,
  output logic            out_valid
);
  import piqp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_INS, S_PLACE, S_COPY, S_CMP_LD, S_COMPACT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        ctl.setup = 1'b1;
        priority if (sts.is_put) begin
          if (sts.full) begin
            state_nxt = S_DONE;
          end else begin
            ctl.ld_ins = 1'b1;
            state_nxt  = S_INS;
          end
        end else if (sts.is_rem) begin
          state_nxt = sts.empty ? S_DONE : S_CMP_LD;
        end else if (sts.is_move) begin
          ctl.ld_copy = 1'b1;
          state_nxt   = S_COPY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS: begin
        ctl.stream = 1'b1;
        if (sts.done) state_nxt = S_PLACE;
      end
      S_PLACE: begin
        ctl.place = 1'b1;
        state_nxt = S_DONE;
      end
      S_COPY: begin
        ctl.stream = 1'b1;
        if (sts.done) state_nxt = S_CMP_LD;
      end
      S_CMP_LD: begin
        ctl.ld_cmp = 1'b1;
        state_nxt  = S_COMPACT;
      end
      S_COMPACT: begin
        ctl.stream = 1'b1;
        if (sts.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      valid_r <= (state_r == S_DONE);
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (out_valid && !busy))
    else $error("result strobe missing after command end");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE))
    else $error("busy out of step with sequencer state");

endmodule

[src/piqp_dpath.sv]
// Queue storage, stream copy engine and result registers.
module piqp_dpath #(
  parameter int DEPTH      = piqp_pkg::DEF_DEPTH,
  parameter int NAME_BYTES = piqp_pkg::DEF_NAME_BYTES,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  piqp_pkg::ctl_t                  ctl,
  output piqp_pkg::sts_t                  sts,
  input  logic [piqp_pkg::CMD_W-1:0]      in_cmd,
  input  logic [piqp_pkg::NAME_W-1:0]     in_name_code,
  input  logic [piqp_pkg::NUM_W-1:0]      in_number,
  input  logic [piqp_pkg::SEM_W-1:0]      in_semester,
  input  logic [piqp_pkg::MCNT_W-1:0]     in_move_count,
  input  logic [piqp_pkg::IDX_W-1:0]      in_read_index,
  output logic [piqp_pkg::STATUS_W-1:0]   out_status,
  output logic [CW-1:0]                   out_waiting_count,
  output logic [CW-1:0]                   out_granted_count,
  output logic [piqp_pkg::NAME_W-1:0]     out_name,
  output logic [piqp_pkg::NUM_W-1:0]      out_number,
  output logic [piqp_pkg::SEM_W-1:0]      out_semester
);
  import piqp_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int NBW   = NAME_BYTES * 8;
  localparam int REC_W = NBW + SEM_W + NUM_W;
  localparam int MW    = (CW > MCNT_W) ? CW : MCNT_W;

  // latched item
  cmd_t              cmd_r;
  logic [NBW-1:0]    name_r;
  logic [NUM_W-1:0]  num_r;
  logic [SEM_W-1:0]  sem_r;
  logic [MCNT_W-1:0] mcnt_r;
  logic [IDX_W-1:0]  ridx_r;

  // queue sizes and per-command scratch
  logic [CW-1:0] wsize_r, wsize_nxt;
  logic [CW-1:0] gsize_r, gsize_nxt;
  logic [CW-1:0] pos_r, n_r;
  status_t       status_r;
  logic          rd_ok_r;

  // stream engine
  logic [CW-1:0] s_cnt_r, s_cnt_nxt;
  logic [AW-1:0] s_idx_r, s_idx_nxt;
  logic [AW-1:0] s_off_r, s_off_nxt;
  logic          s_down_r, s_down_nxt;
  logic          s_dst_g_r, s_dst_g_nxt;
  logic          p_vld_r;
  logic [AW-1:0] p_addr_r;
  logic          step;

  // storage
  logic [REC_W-1:0] w_mem [DEPTH];
  logic [REC_W-1:0] g_mem [DEPTH];
  logic [REC_W-1:0] w_rdata_r, g_rdata_r, w_wdata, rd_rec;
  logic [AW-1:0]    w_raddr, w_waddr, g_raddr;
  logic             w_we, g_we;

  // command evaluation
  logic          is_put, is_rem, is_move, is_read;
  logic          full, empty, mv_short, idx_ok;
  logic [NUM_W-1:0] pm1;
  logic [CW-1:0] pos_c, n_mv, sel_size;
  logic [MW-1:0] mc, ws, fr, nmin_a, nmin_b;

  always_comb begin
    is_put  = (cmd_r == CMD_APPEND) || (cmd_r == CMD_INSERT);
    is_rem  = (cmd_r == CMD_REMOVE);
    is_move = (cmd_r == CMD_MOVE);
    is_read = (cmd_r == CMD_READ_W) || (cmd_r == CMD_READ_G);
    full    = (wsize_r == CW'(DEPTH));
    empty   = (wsize_r == '0);

    // position zero counts as the head; past the tail appends
    pm1 = (num_r == '0) ? '0 : num_r - NUM_W'(1);
    if (cmd_r == CMD_INSERT && pm1 < NUM_W'(wsize_r)) pos_c = CW'(pm1);
    else                                              pos_c = wsize_r;

    mc       = MW'(mcnt_r);
    ws       = MW'(wsize_r);
    fr       = MW'(CW'(DEPTH) - gsize_r);
    nmin_a   = (mc < ws) ? mc : ws;
    nmin_b   = (nmin_a < fr) ? nmin_a : fr;
    mv_short = (nmin_b != mc);
    n_mv     = CW'(nmin_b);

    sel_size = (cmd_r == CMD_READ_G) ? gsize_r : wsize_r;
    idx_ok   = (MW'(ridx_r) < MW'(sel_size));
  end

  always_comb begin
    sts.is_put  = is_put;
    sts.is_rem  = is_rem;
    sts.is_move = is_move;
    sts.full    = full;
    sts.empty   = empty;
    sts.done    = (s_cnt_r == '0) && !p_vld_r;
  end

  // stream: read one waiting entry a cycle, write it in the following cycle at idx + off
  assign step = ctl.stream && (s_cnt_r != '0);

  always_comb begin
    s_cnt_nxt   = s_cnt_r;
    s_idx_nxt   = s_idx_r;
    s_off_nxt   = s_off_r;
    s_down_nxt  = s_down_r;
    s_dst_g_nxt = s_dst_g_r;
    wsize_nxt   = wsize_r;
    gsize_nxt   = gsize_r;
    priority if (ctl.ld_ins) begin
      s_cnt_nxt   = wsize_r - pos_c;
      s_idx_nxt   = AW'(wsize_r - CW'(1));
      s_off_nxt   = AW'(1);
      s_down_nxt  = 1'b1;
      s_dst_g_nxt = 1'b0;
    end else if (ctl.ld_copy) begin
      s_cnt_nxt   = n_mv;
      s_idx_nxt   = '0;
      s_off_nxt   = AW'(gsize_r);
      s_down_nxt  = 1'b0;
      s_dst_g_nxt = 1'b1;
      gsize_nxt   = gsize_r + n_mv;
    end else if (ctl.ld_cmp) begin
      s_cnt_nxt   = wsize_r - n_r;
      s_idx_nxt   = AW'(n_r);
      s_off_nxt   = AW'(0) - AW'(n_r);
      s_down_nxt  = 1'b0;
      s_dst_g_nxt = 1'b0;
      wsize_nxt   = wsize_r - n_r;
    end else if (ctl.place) begin
      wsize_nxt = wsize_r + CW'(1);
    end else if (step) begin
      s_cnt_nxt = s_cnt_r - CW'(1);
      s_idx_nxt = s_down_r ? s_idx_r - AW'(1) : s_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= '0;
      gsize_r <= '0;
      s_cnt_r <= '0;
      p_vld_r <= 1'b0;
    end else begin
      wsize_r <= wsize_nxt;
      gsize_r <= gsize_nxt;
      s_cnt_r <= s_cnt_nxt;
      p_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    s_idx_r   <= s_idx_nxt;
    s_off_r   <= s_off_nxt;
    s_down_r  <= s_down_nxt;
    s_dst_g_r <= s_dst_g_nxt;
    p_addr_r  <= s_idx_r + s_off_r;
    if (ctl.load) begin
      cmd_r  <= cmd_t'(in_cmd);
      name_r <= in_name_code[NBW-1:0];
      num_r  <= in_number;
      sem_r  <= in_semester;
      mcnt_r <= in_move_count;
      ridx_r <= in_read_index;
    end
    if (ctl.setup) begin
      pos_r   <= pos_c;
      n_r     <= is_move ? n_mv : CW'(1);
      rd_ok_r <= is_read && idx_ok;
      priority if (is_put)  status_r <= full ? ST_FULL : ST_OK;
      else if (is_rem)      status_r <= empty ? ST_EMPTY : ST_OK;
      else if (is_move)     status_r <= mv_short ? ST_FULL : ST_OK;
      else if (is_read)     status_r <= idx_ok ? ST_OK : ST_EMPTY;
      else                  status_r <= ST_OK;
    end
  end

  // memory ports
  always_comb begin
    w_raddr = ctl.stream ? s_idx_r : AW'(ridx_r);
    g_raddr = AW'(ridx_r);
    w_we    = ctl.place || (p_vld_r && !s_dst_g_r);
    w_waddr = ctl.place ? AW'(pos_r) : p_addr_r;
    w_wdata = ctl.place ? {name_r, sem_r, num_r} : w_rdata_r;
    g_we    = p_vld_r && s_dst_g_r;
  end

  always_ff @(posedge clk) begin
    w_rdata_r <= w_mem[w_raddr];
    if (w_we) w_mem[w_waddr] <= w_wdata;
  end

  always_ff @(posedge clk) begin
    g_rdata_r <= g_mem[g_raddr];
    if (g_we) g_mem[p_addr_r] <= w_rdata_r;
  end

  // result registers
  assign rd_rec = (cmd_r == CMD_READ_G) ? g_rdata_r : w_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_status        <= status_r;
      out_waiting_count <= wsize_r;
      out_granted_count <= gsize_r;
      out_name          <= rd_ok_r ? NAME_W'(rd_rec[REC_W-1 -: NBW]) : '0;
      out_semester      <= rd_ok_r ? rd_rec[NUM_W +: SEM_W] : '0;
      out_number        <= rd_ok_r ? rd_rec[NUM_W-1:0] : '0;
    end
  end

  a_wsize_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wsize_r <= CW'(DEPTH))
    else $error("waiting count beyond depth");

  a_gsize_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gsize_r <= CW'(DEPTH))
    else $error("granted count beyond depth");

  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.place |-> (wsize_r < CW'(DEPTH)) && (s_cnt_r == '0) && !p_vld_r)
    else $error("record placed into full queue or during a shift");

endmodule

[src/positional_insert_queue_pair.sv]
// Top level of the positional-insert queue pair: sequencer plus datapath.
//
// Two record queues of DEPTH entries, waiting and granted. A command is
// taken when start is high and busy is low; busy then stays high until the
// single result cycle, in which out_valid is high for exactly one clock and
// busy is already low, so the next command may be taken in that same cycle.
// The receiver cannot stall: the result must be captured while out_valid is
// high. Each queue sits in a memory with one write and one registered read
// port, and entries are shifted through that read-then-write path one a
// cycle. Reads, remove on empty, rejected puts and unused codes shift
// nothing; append/insert shifts the k entries behind the insert slot up
// by one, remove compacts the remaining waiting entries, and move copies
// up to the move count into granted, then compacts waiting. No clearing
// pass after reset: storage contents are only used below the current
// counts.
module positional_insert_queue_pair #(
  parameter int DEPTH      = piqp_pkg::DEF_DEPTH,
  parameter int NAME_BYTES = piqp_pkg::DEF_NAME_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [piqp_pkg::CMD_W-1:0]           in_cmd,
  input  logic [piqp_pkg::NAME_W-1:0]          in_name_code,
  input  logic [piqp_pkg::NUM_W-1:0]           in_number,
  input  logic [piqp_pkg::SEM_W-1:0]           in_semester,
  input  logic [piqp_pkg::MCNT_W-1:0]          in_move_count,
  input  logic [piqp_pkg::IDX_W-1:0]           in_read_index,
  output logic                                 out_valid,
  output logic [piqp_pkg::STATUS_W-1:0]        out_status,
  output logic [$clog2(DEPTH+1)-1:0]           out_waiting_count,
  output logic [$clog2(DEPTH+1)-1:0]           out_granted_count,
  output logic [piqp_pkg::NAME_W-1:0]          out_name,
  output logic [piqp_pkg::NUM_W-1:0]           out_number,
  output logic [piqp_pkg::SEM_W-1:0]           out_semester
);
  import piqp_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  ctl_t ctl;   // sequencer commands
  sts_t sts;   // datapath flags

  // sequencer: one state per phase of a command
  piqp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // storage, shift/copy stream and result registers
  piqp_dpath #(
    .DEPTH      (DEPTH),
    .NAME_BYTES (NAME_BYTES),
    .CW         (CW)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_name_code      (in_name_code),
    .in_number         (in_number),
    .in_semester       (in_semester),
    .in_move_count     (in_move_count),
    .in_read_index     (in_read_index),
    .out_status        (out_status),
    .out_waiting_count (out_waiting_count),
    .out_granted_count (out_granted_count),
    .out_name          (out_name),
    .out_number        (out_number),
    .out_semester      (out_semester)
  );

endmodule
